### hw/rtl/bpc_pkg.sv
// Package for the block permutation cipher.
// Holds the field widths, the configuration register indexes, the controller state type
// and the command and status structs. It depends on nothing.
package bpc_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 4;
	localparam int KEY_FIELD_W = 3;
	localparam int KEY_ENTRIES = 8;
	localparam int KEY_W       = KEY_FIELD_W * KEY_ENTRIES;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = KEY_W;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY    = 2'd2;

	localparam logic             MODE_ENCRYPT   = 1'b0;
	localparam logic [LEN_W-1:0] LENGTH_RESET   = 4'd8;
	localparam logic [KEY_W-1:0] KEY_RESET      = 24'd16434824;

	typedef enum logic {
		ST_FILL,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic take;
		logic load;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic flush;
		logic pos_last;
		logic out_free;
	} ctl_sts_t;

endpackage

### hw/rtl/bpc_if.sv
// Valid/ready channel interfaces for the block permutation cipher.
// Input items carry a byte and an end mark; output items carry a byte and block marks.
// Depends on bpc_pkg for the byte width.
interface bpc_feed_if;
	logic                       valid;
	logic                       ready;
	logic [bpc_pkg::BYTE_W-1:0] text_byte;
	logic                       message_end;

	modport source(output valid, output text_byte, output message_end, input ready);
	modport sink(input valid, input text_byte, input message_end, output ready);
endinterface

interface bpc_emit_if;
	logic                       valid;
	logic                       ready;
	logic [bpc_pkg::BYTE_W-1:0] out_byte;
	logic                       block_last;
	logic                       message_done;

	modport source(output valid, output out_byte, output block_last, output message_done,
		input ready);
	modport sink(input valid, input out_byte, input block_last, input message_done,
		output ready);
endinterface

### hw/rtl/bpc_ctrl.sv
// Controller of the block permutation cipher: gathers items until a block flushes,
// then steps the datapath through one output position per free output slot.
// Depends on bpc_pkg.
module bpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              feed_valid,
	output logic              feed_ready,
	input  bpc_pkg::ctl_sts_t sts,
	output bpc_pkg::ctl_cmd_t cmd
);
	import bpc_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (feed_valid && sts.flush) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free && sts.pos_last) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_comb begin
		feed_ready = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_FILL: begin
				feed_ready = 1'b1;
				cmd.take   = feed_valid;
			end
			ST_EMIT: begin
				cmd.load   = sts.out_free;
				cmd.finish = sts.out_free && sts.pos_last;
			end
			default: begin
				feed_ready = 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/bpc_datapath.sv
// Datapath of the block permutation cipher: configuration registers, block store,
// fill and position counters, permutation select and the output register.
// Depends on bpc_pkg; driven by bpc_ctrl.
module bpc_datapath #(
	parameter int MAX_BLOCK = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [bpc_pkg::BYTE_W-1:0]     text_byte,
	input  logic                           message_end,
	input  bpc_pkg::ctl_cmd_t              cmd,
	output bpc_pkg::ctl_sts_t              sts,
	input  logic                           emit_ready,
	output logic                           emit_valid,
	output logic [bpc_pkg::BYTE_W-1:0]     out_byte,
	output logic                           block_last,
	output logic                           message_done
);
	import bpc_pkg::*;

	localparam int IDX_W = $clog2(MAX_BLOCK);

	logic                   mode_q;
	logic [LEN_W-1:0]       length_q;
	logic [KEY_W-1:0]       key_q;
	logic [BYTE_W-1:0]      store_q [MAX_BLOCK];
	logic [IDX_W-1:0]       fill_q;
	logic [IDX_W-1:0]       pos_q;
	logic                   end_q;
	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   block_last_q;
	logic                   message_done_q;

	logic [LEN_W-1:0]       len;
	logic [LEN_W-1:0]       fill_next;
	logic [LEN_W-1:0]       pos_next;
	logic [KEY_FIELD_W-1:0] key_e [MAX_BLOCK];
	logic [KEY_FIELD_W-1:0] key_pos;
	logic [BYTE_W-1:0]      enc_byte;
	logic [BYTE_W-1:0]      dec_byte;
	logic [BYTE_W-1:0]      sel_byte;

	for (genvar g = 0; g < MAX_BLOCK; g++) begin : g_key
		if (g < KEY_ENTRIES) begin : g_used
			assign key_e[g] = key_q[KEY_FIELD_W*g +: KEY_FIELD_W];
		end else begin : g_none
			assign key_e[g] = '0;
		end
	end

	always_comb begin
		if (length_q == '0) begin
			len = LEN_W'(1);
		end else if (length_q > LEN_W'(MAX_BLOCK)) begin
			len = LEN_W'(MAX_BLOCK);
		end else begin
			len = length_q;
		end
	end

	assign fill_next = LEN_W'(fill_q) + LEN_W'(1);
	assign pos_next  = LEN_W'(pos_q) + LEN_W'(1);
	assign key_pos   = key_e[pos_q];

	always_comb begin
		enc_byte = '0;
		if (LEN_W'(key_pos) < len) begin
			for (int i = 0; i < MAX_BLOCK; i++) begin
				if (LEN_W'(i) == LEN_W'(key_pos)) begin
					enc_byte = store_q[i];
				end
			end
		end
	end

	always_comb begin
		dec_byte = '0;
		for (int j = 0; j < MAX_BLOCK; j++) begin
			if (LEN_W'(j) < len && LEN_W'(key_e[j]) == LEN_W'(pos_q)) begin
				dec_byte = store_q[j];
			end
		end
	end

	assign sel_byte = (mode_q == MODE_ENCRYPT) ? enc_byte : dec_byte;

	assign sts.flush    = (fill_next >= len) || message_end;
	assign sts.pos_last = (pos_next == len);
	assign sts.out_free = !out_valid_q || emit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_ENCRYPT;
			length_q <= LENGTH_RESET;
			key_q    <= KEY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_wdata[0];
				CFG_LENGTH: length_q <= cfg_wdata[LEN_W-1:0];
				CFG_KEY:    key_q    <= cfg_wdata[KEY_W-1:0];
				default:    mode_q   <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BLOCK; i++) begin
				store_q[i] <= '0;
			end
			fill_q <= '0;
			pos_q  <= '0;
			end_q  <= 1'b0;
		end else if (cmd.take) begin
			store_q[fill_q] <= text_byte;
			end_q           <= message_end;
			pos_q           <= '0;
			if (!sts.flush) begin
				fill_q <= fill_q + IDX_W'(1);
			end
		end else if (cmd.finish) begin
			for (int i = 0; i < MAX_BLOCK; i++) begin
				store_q[i] <= '0;
			end
			fill_q <= '0;
			pos_q  <= '0;
		end else if (cmd.load) begin
			pos_q <= pos_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (emit_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q     <= sel_byte;
			block_last_q   <= sts.pos_last;
			message_done_q <= sts.pos_last && end_q;
		end
	end

	assign emit_valid   = out_valid_q;
	assign out_byte     = out_byte_q;
	assign block_last   = block_last_q;
	assign message_done = message_done_q;

endmodule

### hw/rtl/block_permutation_cipher.sv
// Block permutation cipher, top level: joins bpc_ctrl and bpc_datapath to the channels.
// After the item that closes a block, the controller enters its emit state and loads
// each output position into the output register whenever the output slot is free.
// It takes no item until every output position of the block has been loaded.
// Reset: arst_n clears the block store, counters and output valid at once and
// restores encrypt mode, length eight and the default key.
module block_permutation_cipher #(
	parameter int MAX_BLOCK = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	bpc_feed_if.sink                       feed,
	bpc_emit_if.source                     emit
);
	import bpc_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	bpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (feed.valid),
		.feed_ready (feed.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	bpc_datapath #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.text_byte    (feed.text_byte),
		.message_end  (feed.message_end),
		.cmd          (cmd),
		.sts          (sts),
		.emit_ready   (emit.ready),
		.emit_valid   (emit.valid),
		.out_byte     (emit.out_byte),
		.block_last   (emit.block_last),
		.message_done (emit.message_done)
	);

endmodule

### hw/rtl/bpc_checker.sv
// Port checker for the block permutation cipher, bound to the top level.
// Watches the feed and emit channels; depends on nothing else.
module bpc_checker (
	input logic clk,
	input logic arst_n,
	input logic feed_valid,
	input logic feed_ready,
	input logic feed_end,
	input logic emit_valid,
	input logic emit_ready,
	input logic emit_block_last,
	input logic emit_message_done
);

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && !emit_ready |=> emit_valid)
		else $error("emit item dropped while stalled");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && emit_message_done |-> emit_block_last)
		else $error("message_done without block_last");

	a_no_feed_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && !emit_block_last |-> !feed_ready)
		else $error("item taken while a block is still being emitted");

	a_end_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		feed_valid && feed_ready && feed_end |=> !feed_ready)
		else $error("end of message did not start a flush");

endmodule

bind block_permutation_cipher bpc_checker u_bpc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.feed_valid        (feed.valid),
	.feed_ready        (feed.ready),
	.feed_end          (feed.message_end),
	.emit_valid        (emit.valid),
	.emit_ready        (emit.ready),
	.emit_block_last   (emit.block_last),
	.emit_message_done (emit.message_done)
);
